>>> rtl/core/mlp_jump_decision_unit_assert.svh
// Assertion macros for the jump decision perceptron.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef MLP_JUMP_DECISION_UNIT_ASSERT_SVH
`define MLP_JUMP_DECISION_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MJD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mjd: assertion failed");
// next-cycle implication
`define MJD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mjd: assertion failed");
`else
`define MJD_ASSERT_IMP(lbl, ante, cons)
`define MJD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/mjd_pkg.sv
// Shared types, constants and sizing functions for the jump decision perceptron.
// No dependencies.
package mjd_pkg;

	localparam int DATA_W        = 16;
	localparam int IDX_PORT_W    = 6;
	localparam int N_FEATURES    = 5;
	localparam int DEF_N_INPUTS  = 5;
	localparam int DEF_N_HIDDEN  = 8;
	localparam int DEF_FRAC_BITS = 12;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_INFER = 1'b1;

	// operand fed to the multiplier alongside the weight word
	typedef enum logic [1:0] {
		OP_FEAT,
		OP_SCALE,
		OP_HID
	} opsel_t;

	// one multiply-accumulate term issued by the controller
	typedef struct packed {
		logic   valid;
		logic   first;
		logic   last_hid;
		logic   last_out;
		opsel_t opsel;
	} mjd_cmd_t;

	// decoded request at the accept edge
	typedef struct packed {
		logic wr;
		logic cap;
	} mjd_req_t;

	typedef struct packed {
		logic res_fin;
	} mjd_status_t;

	function automatic int store_depth(int ni, int nh);
		return nh * ni + 2 * nh + 1;
	endfunction

	function automatic int addr_w(int ni, int nh);
		return $clog2(store_depth(ni, nh));
	endfunction

	function automatic int idx_w(int ni, int nh);
		int m;
		m = (ni > nh) ? ni : nh;
		return (m > 1) ? $clog2(m) : 1;
	endfunction

endpackage

>>> rtl/core/mjd_ctrl.sv
// Sequencer for the jump decision perceptron: walks the weight store term by term.
// Depends on mjd_pkg.
module mjd_ctrl #(
	parameter int N_INPUTS = mjd_pkg::DEF_N_INPUTS,
	parameter int N_HIDDEN = mjd_pkg::DEF_N_HIDDEN,
	localparam int ADDR_W  = mjd_pkg::addr_w(N_INPUTS, N_HIDDEN),
	localparam int IX_W    = mjd_pkg::idx_w(N_INPUTS, N_HIDDEN)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                req_type,
	output logic                busy,
	output mjd_pkg::mjd_req_t    req,
	output mjd_pkg::mjd_cmd_t    cmd,
	output logic [ADDR_W-1:0]   addr,
	output logic [IX_W-1:0]     idx,
	input  mjd_pkg::mjd_status_t status
);
	import mjd_pkg::*;

	localparam int BIAS1_BASE = N_HIDDEN * N_INPUTS;
	localparam int W2_BASE    = BIAS1_BASE + N_HIDDEN;
	localparam int BIAS2_ADDR = W2_BASE + N_HIDDEN;
	localparam int MAX_TERM   = (N_INPUTS > N_HIDDEN) ? N_INPUTS : N_HIDDEN;
	localparam int TW         = $clog2(MAX_TERM + 1);
	localparam int UW         = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HID,
		S_DRAIN,
		S_OUT,
		S_WAIT
	} state_t;

	state_t            state_q;
	logic [UW-1:0]     unit_q;
	logic [TW-1:0]     term_q;
	logic [ADDR_W-1:0] wptr_q;
	mjd_cmd_t          cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IX_W-1:0]   idx_q;

	assign busy    = (state_q != S_IDLE);
	assign req.wr  = start && !busy && (req_type == REQ_LOAD);
	assign req.cap = start && !busy && (req_type == REQ_INFER);
	assign cmd     = cmd_q;
	assign addr    = addr_q;
	assign idx     = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			unit_q  <= '0;
			term_q  <= '0;
			wptr_q  <= '0;
			cmd_q   <= '0;
			addr_q  <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cmd_q <= '0;
					if (req.cap) begin
						state_q <= S_HID;
						unit_q  <= '0;
						term_q  <= '0;
						wptr_q  <= '0;
					end
				end
				S_HID: begin
					// term 0 is the bias, then one term per input
					cmd_q <= '{valid: 1'b1,
						first: (term_q == '0),
						last_hid: (term_q == TW'(N_INPUTS)),
						last_out: 1'b0,
						opsel: (term_q == '0) ? OP_SCALE : OP_FEAT};
					if (term_q == '0) begin
						addr_q      <= ADDR_W'(BIAS1_BASE) + ADDR_W'(unit_q);
						idx_q       <= '0;
					end else begin
						addr_q      <= wptr_q;
						wptr_q      <= wptr_q + 1'b1;
						idx_q       <= IX_W'(term_q - 1'b1);
					end
					if (term_q == TW'(N_INPUTS)) begin
						term_q <= '0;
						if (unit_q == UW'(N_HIDDEN - 1)) begin
							state_q <= S_DRAIN;
						end else begin
							unit_q <= unit_q + 1'b1;
						end
					end else begin
						term_q <= term_q + 1'b1;
					end
				end
				S_DRAIN: begin
					// gap so the last hidden value settles before the output layer
					cmd_q   <= '0;
					state_q <= S_OUT;
					term_q  <= '0;
				end
				S_OUT: begin
					cmd_q <= '{valid: 1'b1,
						first: (term_q == '0),
						last_hid: 1'b0,
						last_out: (term_q == TW'(N_HIDDEN)),
						opsel: (term_q == '0) ? OP_SCALE : OP_HID};
					if (term_q == '0) begin
						addr_q      <= ADDR_W'(BIAS2_ADDR);
						idx_q       <= '0;
					end else begin
						addr_q      <= ADDR_W'(W2_BASE) + ADDR_W'(term_q - 1'b1);
						idx_q       <= IX_W'(term_q - 1'b1);
					end
					if (term_q == TW'(N_HIDDEN)) begin
						state_q <= S_WAIT;
					end else begin
						term_q <= term_q + 1'b1;
					end
				end
				S_WAIT: begin
					cmd_q <= '0;
					if (status.res_fin) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					cmd_q   <= '0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/mjd_dpath.sv
// Datapath of the jump decision perceptron: weight store, shared multiplier,
// accumulator, hidden value registers and result registers. Depends on mjd_pkg.
module mjd_dpath #(
	parameter int N_INPUTS  = mjd_pkg::DEF_N_INPUTS,
	parameter int N_HIDDEN  = mjd_pkg::DEF_N_HIDDEN,
	parameter int FRAC_BITS = mjd_pkg::DEF_FRAC_BITS,
	localparam int ADDR_W   = mjd_pkg::addr_w(N_INPUTS, N_HIDDEN),
	localparam int IX_W     = mjd_pkg::idx_w(N_INPUTS, N_HIDDEN)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mjd_pkg::mjd_req_t                    req,
	input  mjd_pkg::mjd_cmd_t                    cmd,
	input  logic [ADDR_W-1:0]                   addr,
	input  logic [IX_W-1:0]                     idx,
	input  logic [mjd_pkg::IDX_PORT_W-1:0]      weight_index,
	input  logic signed [mjd_pkg::DATA_W-1:0]   weight_value,
	input  logic signed [mjd_pkg::DATA_W-1:0]   feat_y,
	input  logic signed [mjd_pkg::DATA_W-1:0]   feat_vel,
	input  logic signed [mjd_pkg::DATA_W-1:0]   feat_ground,
	input  logic signed [mjd_pkg::DATA_W-1:0]   feat_dist,
	input  logic signed [mjd_pkg::DATA_W-1:0]   feat_height,
	output mjd_pkg::mjd_status_t                 status,
	output logic                                valid,
	output logic                                jump,
	output logic signed [mjd_pkg::DATA_W-1:0]   score
);
	import mjd_pkg::*;

	localparam int DEPTH   = store_depth(N_INPUTS, N_HIDDEN);
	localparam int MAX_NH  = (N_INPUTS > N_HIDDEN) ? N_INPUTS : N_HIDDEN;
	localparam int ACC_W   = 2 * DATA_W + $clog2(MAX_NH + 1);
	localparam int PROD_W  = 2 * DATA_W;
	localparam int FI_W    = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
	localparam int HI_W    = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
	localparam int CW      = (ADDR_W > IDX_PORT_W) ? ADDR_W : IDX_PORT_W;

	localparam logic signed [DATA_W-1:0] SCALE  = DATA_W'(1 << FRAC_BITS);
	localparam logic signed [ACC_W-1:0]  SAT_HI =
		{{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0]  SAT_LO =
		{{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

	logic signed [DATA_W-1:0] store_mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;
	logic [CW-1:0]            widx;
	logic                     in_range;

	logic signed [DATA_W-1:0] feat_in [N_FEATURES];
	logic signed [DATA_W-1:0] feat_q  [N_INPUTS];
	logic signed [DATA_W-1:0] hid_q   [N_HIDDEN];
	logic [HI_W-1:0]          hptr_q;

	mjd_cmd_t                 cmd_s1;
	mjd_cmd_t                 cmd_s2;
	logic [IX_W-1:0]          idx_s1;
	logic signed [DATA_W-1:0] op_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_sh;
	logic                     fin_hid_s3;
	logic                     fin_out_s3;
	logic signed [DATA_W-1:0] hid_val;
	logic signed [DATA_W-1:0] score_val;

	logic                     done_q;
	logic                     jump_q;
	logic signed [DATA_W-1:0] score_q;

	assign widx     = CW'(weight_index);
	assign in_range = (widx < CW'(DEPTH));

	// loads beyond the store are dropped
	always_ff @(posedge clk) begin
		if (req.wr && in_range) begin
			store_mem[widx[ADDR_W-1:0]] <= weight_value;
		end
		rdata_q <= store_mem[addr];
	end

	assign feat_in[0] = feat_y;
	assign feat_in[1] = feat_vel;
	assign feat_in[2] = feat_ground;
	assign feat_in[3] = feat_dist;
	assign feat_in[4] = feat_height;

	for (genvar j = 0; j < N_INPUTS; j++) begin : g_feat
		if (j < N_FEATURES) begin : g_port
			always_ff @(posedge clk) begin
				if (req.cap) begin
					feat_q[j] <= feat_in[j];
				end
			end
		end else begin : g_zero
			always_ff @(posedge clk) begin
				feat_q[j] <= '0;
			end
		end
	end

	always_comb begin
		unique case (cmd_s1.opsel)
			OP_FEAT:  op_s1 = feat_q[idx_s1[FI_W-1:0]];
			OP_SCALE: op_s1 = SCALE;
			OP_HID:   op_s1 = hid_q[idx_s1[HI_W-1:0]];
			default:  op_s1 = '0;
		endcase
	end

	assign prod_ext = $signed({{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2});
	assign acc_sh   = acc_q >>> FRAC_BITS;

	// ReLU, truncate to Q4.12, clamp high
	always_comb begin
		if (acc_q[ACC_W-1]) begin
			hid_val = '0;
		end else if (acc_sh > SAT_HI) begin
			hid_val = SAT_HI[DATA_W-1:0];
		end else begin
			hid_val = acc_sh[DATA_W-1:0];
		end
	end

	always_comb begin
		if (acc_sh > SAT_HI) begin
			score_val = SAT_HI[DATA_W-1:0];
		end else if (acc_sh < SAT_LO) begin
			score_val = SAT_LO[DATA_W-1:0];
		end else begin
			score_val = acc_sh[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1     <= '0;
			cmd_s2     <= '0;
			fin_hid_s3 <= 1'b0;
			fin_out_s3 <= 1'b0;
			done_q     <= 1'b0;
			hptr_q     <= '0;
		end else begin
			cmd_s1     <= cmd;
			cmd_s2     <= cmd_s1;
			fin_hid_s3 <= cmd_s2.valid && cmd_s2.last_hid;
			fin_out_s3 <= cmd_s2.valid && cmd_s2.last_out;
			done_q     <= fin_out_s3;
			if (req.cap) begin
				hptr_q <= '0;
			end else if (fin_hid_s3) begin
				hptr_q <= hptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx;
		prod_s2 <= PROD_W'(rdata_q) * PROD_W'(op_s1);
		if (cmd_s2.valid) begin
			acc_q <= cmd_s2.first ? prod_ext : acc_q + prod_ext;
		end
		if (fin_hid_s3) begin
			hid_q[hptr_q] <= hid_val;
		end
		if (fin_out_s3) begin
			jump_q  <= !acc_q[ACC_W-1] && (acc_q != '0);
			score_q <= score_val;
		end
	end

	assign status.res_fin = fin_out_s3;
	assign valid          = done_q;
	assign jump           = jump_q;
	assign score          = score_q;

endmodule

>>> rtl/core/mlp_jump_decision_unit.sv
// Top level of the jump decision perceptron: controller plus datapath.
// Depends on mjd_pkg, mjd_ctrl, mjd_dpath and mlp_jump_decision_unit_assert.svh.
`include "mlp_jump_decision_unit_assert.svh"

// Two-layer perceptron (N_INPUTS inputs, N_HIDDEN ReLU units, one output) in
// signed Q4.12. An item is taken when start is high and busy is low. A load
// item (req_type 0) writes weight_value into the weight store at weight_index
// at that edge; busy stays low, so loads can follow every cycle, and a load
// beyond the store is dropped. Every store word must be loaded before an
// infer item reads it. An infer item (req_type 1) raises busy and runs all
// N_HIDDEN*(N_INPUTS+1) + N_HIDDEN+1 multiply-accumulates through one shared
// multiplier, one store read per cycle apart from a drain gap between the
// layers; the result passes the store read, multiplier, accumulator and
// result registers and is shown on jump and score, with valid high for a
// single cycle as busy drops. The receiver cannot stall: sample the result
// while valid is high. Store layout: hidden weights row-major, hidden
// biases, output weights, output bias.
module mlp_jump_decision_unit #(
	parameter int N_INPUTS  = mjd_pkg::DEF_N_INPUTS,
	parameter int N_HIDDEN  = mjd_pkg::DEF_N_HIDDEN,
	parameter int FRAC_BITS = mjd_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              req_type,
	input  logic [mjd_pkg::IDX_PORT_W-1:0]    weight_index,
	input  logic signed [mjd_pkg::DATA_W-1:0] weight_value,
	input  logic signed [mjd_pkg::DATA_W-1:0] feat_y,
	input  logic signed [mjd_pkg::DATA_W-1:0] feat_vel,
	input  logic signed [mjd_pkg::DATA_W-1:0] feat_ground,
	input  logic signed [mjd_pkg::DATA_W-1:0] feat_dist,
	input  logic signed [mjd_pkg::DATA_W-1:0] feat_height,
	output logic                              valid,
	output logic                              jump,
	output logic signed [mjd_pkg::DATA_W-1:0] score
);
	import mjd_pkg::*;

	localparam int ADDR_W = addr_w(N_INPUTS, N_HIDDEN);
	localparam int IX_W   = idx_w(N_INPUTS, N_HIDDEN);

	mjd_req_t          req;
	mjd_cmd_t          cmd;
	mjd_status_t       status;
	logic [ADDR_W-1:0] addr;
	logic [IX_W-1:0]   idx;

	mjd_ctrl #(
		.N_INPUTS (N_INPUTS),
		.N_HIDDEN (N_HIDDEN)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.busy     (busy),
		.req      (req),
		.cmd      (cmd),
		.addr     (addr),
		.idx      (idx),
		.status   (status)
	);

	mjd_dpath #(
		.N_INPUTS  (N_INPUTS),
		.N_HIDDEN  (N_HIDDEN),
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.cmd          (cmd),
		.addr         (addr),
		.idx          (idx),
		.weight_index (weight_index),
		.weight_value (weight_value),
		.feat_y       (feat_y),
		.feat_vel     (feat_vel),
		.feat_ground  (feat_ground),
		.feat_dist    (feat_dist),
		.feat_height  (feat_height),
		.status       (status),
		.valid        (valid),
		.jump         (jump),
		.score        (score)
	);

	// an infer ends only with its result, and a result never overlaps work
	`MJD_ASSERT_IMP(a_busy_ends_with_result, $fell(busy), valid)
	`MJD_ASSERT_IMP(a_result_when_idle, valid, !busy)
	`MJD_ASSERT_NXT(a_infer_raises_busy, start && !busy && (req_type == REQ_INFER), busy)
	`MJD_ASSERT_NXT(a_load_stays_idle, start && !busy && (req_type == REQ_LOAD), !busy && !valid)

endmodule
